@@ src/spc_pkg.sv @@
// Shared types and constants for the servo pulse channel block.
package spc_pkg;

    localparam int OP_W      = 2;
    localparam int CH_W      = 3;
    localparam int PCT_W     = 7;
    localparam int PIN_W     = 8;
    localparam int PERIOD_W  = 15;
    localparam int WIDTH_W   = 16;
    localparam int RANGE_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = 23;
    localparam int DEN_W     = 16;

    // Reciprocal of 100 scaled by 2**30; exact for every product below 14 million.
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam int CHANNELS_DEF     = 8;
    localparam int PERIOD_TICKS_DEF = 20000;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 32'h0802_03B6;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1500;
    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic                 hit;
        logic [RANGE_W-1:0]   span_word;
        logic [WIDTH_W-1:0]   width;
    } sel_t;

endpackage

@@ src/spc_cell.sv @@
// One channel cell: range and pulse width registers, pin compare and a chain stage.
module spc_cell #(
    parameter int IDX = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [spc_pkg::RANGE_W-1:0]    cfg_wr_data,
    input  logic                           width_we,
    input  logic [spc_pkg::WIDTH_W-1:0]    width_wdata,
    input  logic [spc_pkg::CH_W-1:0]       sel_ch,
    input  logic [spc_pkg::PERIOD_W-1:0]   count,
    input  spc_pkg::sel_t                  chain_in,
    output spc_pkg::sel_t                  chain_out,
    output logic                           pin
);
    import spc_pkg::*;

    logic [RANGE_W-1:0] range_reg;
    logic [WIDTH_W-1:0] width_reg;
    sel_t               chain_reg;
    sel_t               chain_next;
    logic               hit_me;

    assign hit_me = (int'(sel_ch) == IDX);

    always_comb begin
        if (hit_me) begin
            chain_next.hit       = 1'b1;
            chain_next.span_word = range_reg;
            chain_next.width     = width_reg;
        end else begin
            chain_next = chain_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
            width_reg <= WIDTH_RESET;
        end else begin
            if (cfg_wr_en && (int'(cfg_wr_index) == IDX)) begin
                range_reg <= cfg_wr_data;
            end
            if (width_we && hit_me) begin
                width_reg <= width_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        chain_reg <= chain_next;
    end

    assign chain_out = chain_reg;
    assign pin       = ({1'b0, count} < width_reg);

endmodule

@@ src/spc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
module spc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [spc_pkg::NUM_W-1:0]   num,
    input  logic [spc_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [spc_pkg::NUM_W-1:0]   quotient
);
    import spc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, den_reg};
        if (!trial[DEN_W+1]) begin
            rem_next = trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ src/servo_pwm_channels_unit.sv @@
// Top level of the multi-channel servo pulse generator.
// Each channel cell holds a minimum/maximum range and a pulse width in microseconds; a tick
// word advances the period counter and pin_levels shows which pulses are high. A tick or
// no-op word goes straight to delivery, and a new word is taken only once the block is idle
// again. The addressed channel's data walks the cell chain; a set word then maps the percent
// with a multiplication by the reciprocal of 100, while a read word uses a 23-step shared
// divider. A read of a range whose minimum equals its maximum, or a word for a missing
// channel, skips that arithmetic.
// The result sits in an output register, so the next word is taken while it waits; a result
// that is ready while the previous one is still held waits for the output to drain.
// No clearing pass follows reset.
module servo_pwm_channels_unit #(
    parameter int CHANNELS     = spc_pkg::CHANNELS_DEF,
    parameter int PERIOD_TICKS = spc_pkg::PERIOD_TICKS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // percent[6:0], zero pad
    input  logic [4:0]                     s_tuser,  // operation[1:0], channel[4:2]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // pin_levels[7:0], width_percent[14:8]
    input  logic                           cfg_wr_en,
    input  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [spc_pkg::RANGE_W-1:0]    cfg_wr_data
);
    import spc_pkg::*;

    localparam int GC_W = $clog2(CHANNELS + 1);
    localparam logic [PERIOD_W:0] PERIOD_LIM = (PERIOD_W + 1)'(PERIOD_TICKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GATHER,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_FINISH,
        S_CAPTURE,
        S_DELIVER
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic [GC_W-1:0]     gcnt_reg, gcnt_next;
    logic [WIDTH_W-1:0]  mn_reg, mn_next;
    logic                neg_reg, neg_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [WIDTH_W-1:0]  setq_reg, setq_next;
    logic                div_start_reg, div_start_next;
    logic [PIN_W-1:0]    res_pins_reg, res_pins_next;
    logic [PCT_W-1:0]    res_pct_reg, res_pct_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    sel_t                chain [CHANNELS+1];
    logic [CHANNELS-1:0] pins_all;
    logic [PIN_W-1:0]    pins8;

    logic                width_we;
    logic [WIDTH_W-1:0]  width_wdata;
    logic                div_done;
    logic [NUM_W-1:0]    quotient;

    logic [WIDTH_W-1:0]  mn, mx;
    logic [WIDTH_W:0]    span, diff, span_neg, diff_neg;
    logic [DEN_W-1:0]    span_mag, diff_mag;
    logic [PCT_W-1:0]    pct_cl;
    logic [NUM_W-1:0]    set_prod, read_prod;
    logic [NUM_W+RECIP_W-1:0] scale_prod;
    logic [PCT_W-1:0]    read_pct;
    logic                s_fire;

    assign chain[0] = '0;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        spc_cell #(.IDX(i)) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cfg_wr_en   (cfg_wr_en),
            .cfg_wr_index(cfg_wr_index),
            .cfg_wr_data (cfg_wr_data),
            .width_we    (width_we),
            .width_wdata (width_wdata),
            .sel_ch      (ch_reg),
            .count       (count_reg),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .pin         (pins_all[i])
        );
    end

    for (genvar j = 0; j < PIN_W; j++) begin : g_pin
        if (j < CHANNELS) begin : g_used
            assign pins8[j] = pins_all[j];
        end else begin : g_pad
            assign pins8[j] = 1'b0;
        end
    end

    spc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quotient(quotient)
    );

    // Operand preparation from the word that left the end of the chain.
    always_comb begin
        mn        = chain[CHANNELS].span_word[WIDTH_W-1:0];
        mx        = chain[CHANNELS].span_word[RANGE_W-1:WIDTH_W];
        span      = {1'b0, mx} - {1'b0, mn};
        diff      = {1'b0, chain[CHANNELS].width} - {1'b0, mn};
        span_neg  = -span;
        diff_neg  = -diff;
        span_mag  = span[WIDTH_W] ? span_neg[DEN_W-1:0] : span[DEN_W-1:0];
        diff_mag  = diff[WIDTH_W] ? diff_neg[DEN_W-1:0] : diff[DEN_W-1:0];
        pct_cl    = (pct_reg > PCT_MAX) ? PCT_MAX : pct_reg;
        set_prod  = NUM_W'(span_mag) * NUM_W'(pct_cl);
        read_prod = NUM_W'(diff_mag) * NUM_W'(PCT_MAX);
    end

    // Scaled set quotient, and the read quotient signed back and saturated.
    always_comb begin
        scale_prod  = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP_100};
        width_wdata = neg_reg ? (mn_reg - setq_reg) : (mn_reg + setq_reg);
        if (neg_reg) begin
            read_pct = '0;
        end else if (quotient > NUM_W'(PCT_MAX)) begin
            read_pct = PCT_MAX;
        end else begin
            read_pct = quotient[PCT_W-1:0];
        end
    end

    assign width_we = (state_reg == S_FINISH) && (op_reg == OP_SET);
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        pct_next       = pct_reg;
        count_next     = count_reg;
        gcnt_next      = gcnt_reg;
        mn_next        = mn_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        setq_next      = setq_reg;
        div_start_next = 1'b0;
        res_pins_next  = res_pins_reg;
        res_pct_next   = res_pct_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    op_next      = op_t'(s_tuser[1:0]);
                    ch_next      = s_tuser[4:2];
                    pct_next     = s_tdata[PCT_W-1:0];
                    res_pct_next = '0;
                    gcnt_next    = '0;
                    if (op_t'(s_tuser[1:0]) == OP_SET || op_t'(s_tuser[1:0]) == OP_READ) begin
                        state_next = S_GATHER;
                    end else begin
                        res_pins_next = pins8;
                        if (op_t'(s_tuser[1:0]) == OP_TICK) begin
                            if (({1'b0, count_reg} + 1'b1) >= PERIOD_LIM) begin
                                count_next = '0;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        state_next = S_DELIVER;
                    end
                end
            end
            S_GATHER: begin
                gcnt_next = gcnt_reg + 1'b1;
                if (gcnt_reg == GC_W'(CHANNELS - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                mn_next = mn;
                if (!chain[CHANNELS].hit || (op_reg == OP_READ && span == '0)) begin
                    state_next = S_CAPTURE;
                end else if (op_reg == OP_SET) begin
                    num_next   = set_prod;
                    neg_next   = span[WIDTH_W];
                    state_next = S_SCALE;
                end else begin
                    num_next       = read_prod;
                    den_next       = span_mag;
                    neg_next       = diff[WIDTH_W] ^ span[WIDTH_W];
                    div_start_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_SCALE: begin
                setq_next  = scale_prod[RECIP_SHIFT +: WIDTH_W];
                state_next = S_FINISH;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (op_reg == OP_READ) begin
                    res_pct_next = read_pct;
                end
                state_next = S_CAPTURE;
            end
            S_CAPTURE: begin
                res_pins_next = pins8;
                state_next    = S_DELIVER;
            end
            S_DELIVER: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_pct_reg, res_pins_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            gcnt_reg      <= '0;
            div_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            gcnt_reg      <= gcnt_next;
            div_start_reg <= div_start_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tdata_reg   <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        pct_reg      <= pct_next;
        mn_reg       <= mn_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        setq_reg     <= setq_next;
        res_pins_reg <= res_pins_next;
        res_pct_reg  <= res_pct_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/spc_checker.sv @@
// Port-level checks for the servo pulse channel block and their binding.
module spc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [15:0]                    m_tdata
);

    // The block works on one word at a time, so it is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again in the cycle after an accepted word");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:8] <= 7'd100))
        else $error("width_percent above 100");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15] == 1'b0))
        else $error("output pad bit set");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

endmodule

bind servo_pwm_channels_unit spc_checker u_spc_checker (.*);
